[hw/rtl/tmhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ternary min-heap queue package
// Shared constants, codes, types and index helpers of the heap queue core.
// ----------------------------------------------------------------------------
package tmhq_pkg;

   localparam int CAPACITY = 256;
   localparam int ARITY    = 3;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 1;
   localparam int KIDX_W   = 2;

   // Division by three as a multiply by a rounded-up reciprocal.
   localparam int DIV3_SHIFT = ADDR_W + 1;
   localparam int DIV3_MULT  = (2 ** DIV3_SHIFT) / 3 + 1;
   localparam int PROD_W     = ADDR_W + DIV3_SHIFT;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [KIDX_W-1:0] LAST_CHILD = KIDX_W'(ARITY - 1);

   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [CHILD_W-1:0]        child_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_UP_TEST,
      S_UP_CMP,
      S_EX_ROOT,
      S_EX_LAST,
      S_DN_TEST,
      S_DN_CHILD,
      S_DN_DECIDE,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_REJECT_FULL,
      OP_REJECT_EMPTY,
      OP_INS_START,
      OP_EX_START,
      OP_UP_READ,
      OP_UP_MOVE,
      OP_UP_PLACE,
      OP_EX_TAKE,
      OP_EX_LAST,
      OP_DN_FIRST,
      OP_DN_CHILD,
      OP_DN_MOVE,
      OP_DN_PLACE,
      OP_RSP_LOAD
   } op_type;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_extract;
      logic count_zero;
      logic count_full;
      logic idx_zero;
      logic parent_greater;
      logic last_entry;
      logic no_child;
      logic more_child;
      logic child_better;
      logic rsp_free;
   } dp_status_type;

   // Parent slot (i-1)/3; its result is only used for slots other than the root.
   function automatic addr_type parent_of(input addr_type idx);
      addr_type          pred;
      logic [PROD_W-1:0] prod;
      pred = idx - addr_type'(1);
      prod = PROD_W'(pred) * PROD_W'(DIV3_MULT);
      return prod[DIV3_SHIFT +: ADDR_W];
   endfunction

   // Left child slot 3i+1.
   function automatic child_type first_child_of(input addr_type idx);
      return (child_type'(idx) << 1) + child_type'(idx) + child_type'(1);
   endfunction

endpackage

[hw/rtl/tmhq_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue request channel
// Valid/ready channel that carries one command item into the core.
// ----------------------------------------------------------------------------
interface tmhq_req_if;
   logic                          valid;
   logic                          ready;
   logic [tmhq_pkg::CMD_W-1:0]    cmd;
   logic signed [tmhq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

[hw/rtl/tmhq_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue response channel
// Valid/ready channel that carries one result item out of the core.
// ----------------------------------------------------------------------------
interface tmhq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tmhq_pkg::VALUE_W-1:0] result_value;
   logic [tmhq_pkg::STATUS_W-1:0]       status;
   logic [tmhq_pkg::COUNT_W-1:0]        occupancy;

   modport source (output valid, output result_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input result_value, input status, input occupancy,
                   output ready);
endinterface

[hw/rtl/tmhq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tmhq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue controller
// Sequences sift-up and sift-down steps and issues one datapath command
// per cycle.
// ----------------------------------------------------------------------------
module tmhq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tmhq_pkg::dp_status_type dp_status,
   output tmhq_pkg::ctrl_cmd_type  ctrl_cmd
);

   tmhq_pkg::state_type state_ff;
   tmhq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmhq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmhq_pkg::S_IDLE: begin
            if (req_valid) state_in = tmhq_pkg::S_CHECK;
         end
         tmhq_pkg::S_CHECK: begin
            if (dp_status.is_extract) begin
               state_in = dp_status.count_zero ? tmhq_pkg::S_FINISH : tmhq_pkg::S_EX_ROOT;
            end else begin
               state_in = dp_status.count_full ? tmhq_pkg::S_FINISH : tmhq_pkg::S_UP_TEST;
            end
         end
         tmhq_pkg::S_UP_TEST: begin
            state_in = dp_status.idx_zero ? tmhq_pkg::S_FINISH : tmhq_pkg::S_UP_CMP;
         end
         tmhq_pkg::S_UP_CMP: begin
            state_in = dp_status.parent_greater ? tmhq_pkg::S_UP_TEST : tmhq_pkg::S_FINISH;
         end
         tmhq_pkg::S_EX_ROOT: begin
            state_in = dp_status.last_entry ? tmhq_pkg::S_FINISH : tmhq_pkg::S_EX_LAST;
         end
         tmhq_pkg::S_EX_LAST: begin
            state_in = tmhq_pkg::S_DN_TEST;
         end
         tmhq_pkg::S_DN_TEST: begin
            state_in = dp_status.no_child ? tmhq_pkg::S_FINISH : tmhq_pkg::S_DN_CHILD;
         end
         tmhq_pkg::S_DN_CHILD: begin
            state_in = dp_status.more_child ? tmhq_pkg::S_DN_CHILD : tmhq_pkg::S_DN_DECIDE;
         end
         tmhq_pkg::S_DN_DECIDE: begin
            state_in = dp_status.child_better ? tmhq_pkg::S_DN_TEST : tmhq_pkg::S_FINISH;
         end
         tmhq_pkg::S_FINISH: begin
            if (dp_status.rsp_free) state_in = tmhq_pkg::S_IDLE;
         end
         default: begin
            state_in = tmhq_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl_cmd.op = tmhq_pkg::OP_NONE;
      req_ready   = 1'b0;
      case (state_ff)
         tmhq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) ctrl_cmd.op = tmhq_pkg::OP_ACCEPT;
         end
         tmhq_pkg::S_CHECK: begin
            if (dp_status.is_extract) begin
               ctrl_cmd.op = dp_status.count_zero ? tmhq_pkg::OP_REJECT_EMPTY
                                                  : tmhq_pkg::OP_EX_START;
            end else begin
               ctrl_cmd.op = dp_status.count_full ? tmhq_pkg::OP_REJECT_FULL
                                                  : tmhq_pkg::OP_INS_START;
            end
         end
         tmhq_pkg::S_UP_TEST: begin
            ctrl_cmd.op = dp_status.idx_zero ? tmhq_pkg::OP_UP_PLACE : tmhq_pkg::OP_UP_READ;
         end
         tmhq_pkg::S_UP_CMP: begin
            ctrl_cmd.op = dp_status.parent_greater ? tmhq_pkg::OP_UP_MOVE
                                                   : tmhq_pkg::OP_UP_PLACE;
         end
         tmhq_pkg::S_EX_ROOT: begin
            ctrl_cmd.op = tmhq_pkg::OP_EX_TAKE;
         end
         tmhq_pkg::S_EX_LAST: begin
            ctrl_cmd.op = tmhq_pkg::OP_EX_LAST;
         end
         tmhq_pkg::S_DN_TEST: begin
            ctrl_cmd.op = dp_status.no_child ? tmhq_pkg::OP_DN_PLACE : tmhq_pkg::OP_DN_FIRST;
         end
         tmhq_pkg::S_DN_CHILD: begin
            ctrl_cmd.op = tmhq_pkg::OP_DN_CHILD;
         end
         tmhq_pkg::S_DN_DECIDE: begin
            ctrl_cmd.op = dp_status.child_better ? tmhq_pkg::OP_DN_MOVE
                                                 : tmhq_pkg::OP_DN_PLACE;
         end
         tmhq_pkg::S_FINISH: begin
            if (dp_status.rsp_free) ctrl_cmd.op = tmhq_pkg::OP_RSP_LOAD;
         end
         default: begin
            ctrl_cmd.op = tmhq_pkg::OP_NONE;
         end
      endcase
   end

endmodule

[hw/rtl/tmhq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue datapath
// Heap store, entry count, moving value and index registers, and the
// response register.
// ----------------------------------------------------------------------------
module tmhq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tmhq_pkg::ctrl_cmd_type              ctrl_cmd,
   output tmhq_pkg::dp_status_type             dp_status,
   input  logic [tmhq_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [tmhq_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tmhq_pkg::VALUE_W-1:0] rsp_result_value,
   output logic [tmhq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tmhq_pkg::COUNT_W-1:0]        rsp_occupancy
);

   // Control state.
   tmhq_pkg::count_type count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [tmhq_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   tmhq_pkg::value_type           val_ff, val_in;
   tmhq_pkg::addr_type            idx_ff, idx_in;
   tmhq_pkg::addr_type            par_ff, par_in;
   tmhq_pkg::child_type           cidx_ff, cidx_in;
   logic [tmhq_pkg::KIDX_W-1:0]   kidx_ff, kidx_in;
   tmhq_pkg::value_type           best_val_ff, best_val_in;
   tmhq_pkg::addr_type            best_idx_ff, best_idx_in;
   tmhq_pkg::value_type           result_ff, result_in;
   logic [tmhq_pkg::STATUS_W-1:0] status_ff, status_in;
   tmhq_pkg::value_type           rsp_value_ff, rsp_value_in;
   logic [tmhq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   tmhq_pkg::count_type           rsp_occ_ff, rsp_occ_in;

   // Heap store port.
   logic                          wr_en;
   tmhq_pkg::addr_type            wr_addr;
   logic [tmhq_pkg::VALUE_W-1:0]  wr_data;
   tmhq_pkg::addr_type            rd_addr;
   logic [tmhq_pkg::VALUE_W-1:0]  ram_rd_data;
   tmhq_pkg::value_type           rd_data;

   tmhq_pkg::child_type           child_first;
   tmhq_pkg::child_type           cidx_next;
   tmhq_pkg::count_type           count_dec;
   tmhq_pkg::addr_type            parent_idx;
   logic                          child_take;

   tmhq_ram #(
      .WIDTH (tmhq_pkg::VALUE_W),
      .DEPTH (tmhq_pkg::CAPACITY)
   ) u_heap_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_data     = $signed(ram_rd_data);
   assign child_first = tmhq_pkg::first_child_of(idx_ff);
   assign cidx_next   = cidx_ff + tmhq_pkg::child_type'(1);
   assign count_dec   = count_ff - tmhq_pkg::count_type'(1);
   assign parent_idx  = tmhq_pkg::parent_of(idx_ff);
   assign child_take  = (kidx_ff == '0) || (rd_data < best_val_ff);

   always_comb begin
      dp_status.is_extract     = (cmd_ff == tmhq_pkg::CMD_EXTRACT);
      dp_status.count_zero     = (count_ff == '0);
      dp_status.count_full     = (count_ff >= tmhq_pkg::count_type'(tmhq_pkg::CAPACITY));
      dp_status.idx_zero       = (idx_ff == '0);
      dp_status.parent_greater = (rd_data > val_ff);
      dp_status.last_entry     = (count_ff == tmhq_pkg::count_type'(1));
      dp_status.no_child       = (child_first >= tmhq_pkg::child_type'(count_ff));
      dp_status.more_child     = (kidx_ff != tmhq_pkg::LAST_CHILD)
                              && (cidx_next < tmhq_pkg::child_type'(count_ff));
      dp_status.child_better   = (best_val_ff < val_ff);
      dp_status.rsp_free       = !rsp_valid_ff || rsp_ready;
   end

   // Store port control.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = val_ff;
      rd_addr = '0;
      case (ctrl_cmd.op)
         tmhq_pkg::OP_EX_START: begin
            rd_addr = '0;
         end
         tmhq_pkg::OP_UP_READ: begin
            rd_addr = parent_idx;
         end
         tmhq_pkg::OP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         tmhq_pkg::OP_UP_PLACE, tmhq_pkg::OP_DN_PLACE: begin
            wr_en = 1'b1;
         end
         tmhq_pkg::OP_EX_TAKE: begin
            rd_addr = count_dec[tmhq_pkg::ADDR_W-1:0];
         end
         tmhq_pkg::OP_DN_FIRST: begin
            rd_addr = child_first[tmhq_pkg::ADDR_W-1:0];
         end
         tmhq_pkg::OP_DN_CHILD: begin
            rd_addr = cidx_next[tmhq_pkg::ADDR_W-1:0];
         end
         tmhq_pkg::OP_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = best_val_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Register next values.
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      par_in        = par_ff;
      cidx_in       = cidx_ff;
      kidx_in       = kidx_ff;
      best_val_in   = best_val_ff;
      best_idx_in   = best_idx_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      case (ctrl_cmd.op)
         tmhq_pkg::OP_ACCEPT: begin
            cmd_in = req_cmd;
            val_in = req_value;
         end
         tmhq_pkg::OP_REJECT_FULL: begin
            result_in = '0;
            status_in = tmhq_pkg::STATUS_FULL;
         end
         tmhq_pkg::OP_REJECT_EMPTY: begin
            result_in = '0;
            status_in = tmhq_pkg::STATUS_EMPTY;
         end
         tmhq_pkg::OP_INS_START: begin
            idx_in    = count_ff[tmhq_pkg::ADDR_W-1:0];
            result_in = '0;
            status_in = tmhq_pkg::STATUS_OK;
         end
         tmhq_pkg::OP_EX_START: begin
            status_in = tmhq_pkg::STATUS_OK;
         end
         tmhq_pkg::OP_UP_READ: begin
            par_in = parent_idx;
         end
         tmhq_pkg::OP_UP_MOVE: begin
            idx_in = par_ff;
         end
         tmhq_pkg::OP_UP_PLACE: begin
            count_in = count_ff + tmhq_pkg::count_type'(1);
         end
         tmhq_pkg::OP_EX_TAKE: begin
            result_in = rd_data;
            count_in  = count_dec;
         end
         tmhq_pkg::OP_EX_LAST: begin
            val_in = rd_data;
            idx_in = '0;
         end
         tmhq_pkg::OP_DN_FIRST: begin
            cidx_in = child_first;
            kidx_in = '0;
         end
         tmhq_pkg::OP_DN_CHILD: begin
            // The first child always seeds the minimum; later ones replace it
            // only when strictly smaller, so ties keep the lowest slot.
            if (child_take) begin
               best_val_in = rd_data;
               best_idx_in = cidx_ff[tmhq_pkg::ADDR_W-1:0];
            end
            cidx_in = cidx_next;
            kidx_in = kidx_ff + tmhq_pkg::KIDX_W'(1);
         end
         tmhq_pkg::OP_DN_MOVE: begin
            idx_in = best_idx_ff;
         end
         tmhq_pkg::OP_RSP_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = result_ff;
            rsp_status_in = status_ff;
            rsp_occ_in    = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      par_ff        <= par_in;
      cidx_ff       <= cidx_in;
      kidx_ff       <= kidx_in;
      best_val_ff   <= best_val_in;
      best_idx_ff   <= best_idx_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // The entry count never runs past the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tmhq_pkg::count_type'(tmhq_pkg::CAPACITY))
      else $error("entry count exceeds capacity");

   // A rejected insert leaves the heap size untouched.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.op == tmhq_pkg::OP_REJECT_FULL |=> count_ff == $past(count_ff))
      else $error("rejected insert changed the entry count");

   // Sift-up always climbs toward the root.
   a_up_climbs: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.op == tmhq_pkg::OP_UP_MOVE |-> par_ff < idx_ff)
      else $error("sift-up moved away from the root");

   // Sift-down always descends into a child slot.
   a_dn_descends: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.op == tmhq_pkg::OP_DN_MOVE |-> best_idx_ff > idx_ff)
      else $error("sift-down did not descend");

   // A loaded result is offered on the next cycle.
   a_rsp_offered: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.op == tmhq_pkg::OP_RSP_LOAD |=> rsp_valid_ff)
      else $error("loaded result not offered");

endmodule

[hw/rtl/ternary_min_heap_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ternary min-heap queue core
// Priority queue of signed 32-bit values kept as a ternary min-heap.
// ----------------------------------------------------------------------------
// Each request item is an insert (cmd 0) or an extract-minimum (cmd 1), and
// each one yields exactly one response item holding the extracted value
// (zero unless an extract succeeds), a status (ok, extract on empty, insert
// on full) and the number of entries held afterwards. The heap lives in a
// single RAM with one write port and one registered read port, and that one
// read port sets the speed. An insert climbs level by level, each level a
// test and then a parent read and compare, until the new value comes to
// rest. An extract takes the root, moves the last entry into it and lets it
// sink level by level, each level one test, up to three child reads (fewer
// where children are missing) and one decision. Items are taken one at a
// time; the request side reopens as soon as the result is parked in the
// response register, so a new request is accepted while the previous result
// still waits. The store needs no clearing after reset, since only slots
// below the entry count are ever read.
// ----------------------------------------------------------------------------
module ternary_min_heap_queue_core (
   input logic          clock,
   input logic          reset,
   tmhq_req_if.sink     req_ch,
   tmhq_rsp_if.source   rsp_ch
);

   tmhq_pkg::ctrl_cmd_type  ctrl_cmd;
   tmhq_pkg::dp_status_type dp_status;
   logic                    req_ready;

   // The controller walks the heap one step per cycle and tells the
   // datapath which store access and register update to make.
   tmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // The datapath holds the heap store, entry count, the value being sifted
   // and the response register.
   tmhq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl_cmd         (ctrl_cmd),
      .dp_status        (dp_status),
      .req_cmd          (req_ch.cmd),
      .req_value        (req_ch.value),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_status       (rsp_ch.status),
      .rsp_occupancy    (rsp_ch.occupancy)
   );

   assign req_ch.ready = req_ready;

endmodule

[verif/heap_queue_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue scoreboard
// Keeps a private ternary min-heap image, predicts each result item and
// compares the results that leave the core in order.
// ----------------------------------------------------------------------------
package heap_queue_scoreboard_pkg;

   import tmhq_pkg::*;

   typedef struct {
      value_type              result_value;
      logic [STATUS_W-1:0]    status;
      count_type              occupancy;
   } heap_result_type;

   class heap_queue_scoreboard;
      value_type       heap_image [CAPACITY];
      int unsigned     entries;
      heap_result_type pending_q [$];
      int unsigned     mismatches;

      function new();
         entries    = 0;
         mismatches = 0;
      endfunction

      function int unsigned occupancy();
         return entries;
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      function void swap_slots(input int unsigned a, input int unsigned b);
         value_type held;
         held          = heap_image[a];
         heap_image[a] = heap_image[b];
         heap_image[b] = held;
      endfunction

      // Applies one accepted request item to the heap image and queues the
      // result item that the core owes for it.
      function void note_request(input logic [CMD_W-1:0] cmd, input value_type value);
         heap_result_type expected;
         int unsigned     idx;
         int unsigned     up;
         int unsigned     best;
         int unsigned     kid;
         bit              settled;
         expected.result_value = '0;
         expected.status       = STATUS_OK;
         if (cmd == CMD_INSERT) begin
            if (entries >= CAPACITY) begin
               expected.status = STATUS_FULL;
            end else begin
               idx             = entries;
               heap_image[idx] = value;
               settled         = 1'b0;
               while (!settled && idx != 0) begin
                  up = (idx - 1) / ARITY;
                  if (heap_image[up] > heap_image[idx]) begin
                     swap_slots(up, idx);
                     idx = up;
                  end else begin
                     settled = 1'b1;
                  end
               end
               entries++;
            end
         end else if (entries == 0) begin
            expected.status = STATUS_EMPTY;
         end else begin
            expected.result_value = heap_image[0];
            entries--;
            heap_image[0] = heap_image[entries];
            idx           = 0;
            settled       = 1'b0;
            while (!settled) begin
               // Strict compare keeps the lowest-indexed child among equals.
               best = idx;
               for (int k = 1; k <= ARITY; k++) begin
                  kid = ARITY * idx + k;
                  if (kid < entries && heap_image[kid] < heap_image[best]) begin
                     best = kid;
                  end
               end
               if (best == idx) begin
                  settled = 1'b1;
               end else begin
                  swap_slots(idx, best);
                  idx = best;
               end
            end
         end
         expected.occupancy = count_type'(entries);
         pending_q.push_back(expected);
      endfunction

      function void check_result(input value_type got_value,
                                 input logic [STATUS_W-1:0] got_status,
                                 input count_type got_count);
         heap_result_type expected;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"%0t: result item with no request pending: ",
                         "value %0d status %0d count %0d"},
                        $time, got_value, got_status, got_count);
            end
         end else begin
            expected = pending_q.pop_front();
            if (got_value !== expected.result_value || got_status !== expected.status ||
                got_count !== expected.occupancy) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"%0t: result item differs: value exp %0d got %0d, ",
                            "status exp %0d got %0d, count exp %0d got %0d"},
                           $time, expected.result_value, got_value, expected.status,
                           got_status, expected.occupancy, got_count);
               end
            end
         end
      endfunction
   endclass

endpackage

[verif/tb_ternary_min_heap_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ternary min-heap queue core testbench
// Drives insert and extract items through the request channel, with random
// idling on both sides and one long response stall, and checks every result
// item against a scoreboard that keeps its own image of the heap.
// ----------------------------------------------------------------------------
module tb_ternary_min_heap_queue_core;

   import tmhq_pkg::*;
   import heap_queue_scoreboard_pkg::*;

   // Roughly how many request items the random part sends.
   localparam int unsigned ITEM_TARGET   = 1650;
   // Cycles without any handshake before the run is declared hung. The
   // longest honest quiet spell is the deliberate response hold-off below
   // plus a long sender gap and a full-depth extract, well under this.
   localparam int unsigned WATCHDOG_MAX  = 2000;
   // Length of the one deliberate response hold-off, in cycles.
   localparam int unsigned HOLD_OFF_LEN  = 400;
   // Results seen before that hold-off starts.
   localparam int unsigned HOLD_OFF_AT   = 300;
   // Cycles to keep watching after the last expected result; covers the
   // slowest extract with margin.
   localparam int unsigned DRAIN_CYCLES  = 40;

   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tmhq_req_if req_ch ();
   tmhq_rsp_if rsp_ch ();

   ternary_min_heap_queue_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #1 clock = ~clock;

   heap_queue_scoreboard sb = new();

   int unsigned items_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned quiet_cycles  = 0;
   int          send_calm     = 0;
   int          recv_calm     = 0;

   // Idle length for one side. Most gaps are zero or short and a few are
   // long; now and then a side enters a calm stretch with no idling at all.
   function automatic int pick_idle(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end else if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end else begin
         return $urandom_range(25, 70);
      end
   endfunction

   // Insert values: full-range words so every bit toggles, a narrow band
   // that forces ties among siblings, the extremes, and a moderate band.
   function automatic value_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return value_type'($urandom());
      end else if (r < 70) begin
         return value_type'(int'($urandom_range(0, 8)) - 4);
      end else if (r < 80) begin
         case ($urandom_range(0, 5))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return VALUE_MIN + 1;
            3: return VALUE_MAX - 1;
            4: return '0;
            default: return -1;
         endcase
      end else begin
         return value_type'(int'($urandom_range(0, 2000)) - 1000);
      end
   endfunction

   // Offers one item at the falling edge and holds it until the core takes
   // it at a rising edge. Returns at the falling edge after acceptance, so
   // a following item can be presented back to back without dropping valid.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input value_type value);
      int gap;
      gap = pick_idle(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.value <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(cmd, value);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_insert(input value_type value);
      send_item(CMD_INSERT, value);
   endtask

   // The value field of an extract is don't-care, so it carries noise.
   task automatic send_extract();
      send_item(CMD_EXTRACT, value_type'($urandom()));
   endtask

   // Fills the heap to capacity with the odd extract mixed in, then knocks
   // on the full heap a few times. A late phase stops early once the item
   // budget is spent.
   task automatic fill_phase();
      while (sb.occupancy() < CAPACITY && items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            send_extract();
         end else begin
            send_insert(pick_value());
         end
      end
      repeat ($urandom_range(1, 4)) send_insert(pick_value());
   endtask

   // Drains the heap with the odd insert mixed in, then extracts from the
   // empty heap a few times. A late phase stops early once the item budget
   // is spent.
   task automatic drain_phase();
      while (sb.occupancy() != 0 && items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            send_insert(pick_value());
         end else begin
            send_extract();
         end
      end
      repeat ($urandom_range(1, 3)) send_extract();
   endtask

   task automatic mixed_phase();
      repeat ($urandom_range(30, 70)) begin
         if ($urandom_range(0, 1) == 0) begin
            send_insert(pick_value());
         end else begin
            send_extract();
         end
      end
   endtask

   // Request side: reset, a short directed run, then random phases.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_INSERT;
      req_ch.value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: an extract on the empty heap, then both extremes,
      // the values around zero, four equal values so that a sift-down has
      // to pick among tied children, and a second copy of the minimum. The
      // drain that follows returns them all in order and ends with one
      // more extract on the empty heap.
      send_extract();
      send_insert(VALUE_MAX);
      send_insert(VALUE_MIN);
      send_insert('0);
      send_insert(-1);
      send_insert(1);
      repeat (4) send_insert(5);
      send_insert(VALUE_MIN);
      repeat (11) send_extract();

      // Random part. The first two phases take the heap all the way to
      // full and back to empty so that both rejection paths and the
      // deepest sifts are reached early; after that phases are mixed.
      fill_phase();
      drain_phase();
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0: fill_phase();
            1: drain_phase();
            default: mixed_phase();
         endcase
      end
      req_ch.valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      // A stray late result would still be caught here.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Response side: ready is driven at the falling edge and results are
   // taken at the rising edge. Once, after a few hundred results, ready is
   // held low for a long stretch while the sender keeps offering items, so
   // that the parked result blocks the core and the request side stalls.
   initial begin : response_side
      int  stall_left;
      bit  hold_off_done;
      stall_left    = 0;
      hold_off_done = 1'b0;
      rsp_ch.ready  = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_off_done && results_seen >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            stall_left    = HOLD_OFF_LEN;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_idle(recv_calm);
         end
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            sb.check_result(rsp_ch.result_value, rsp_ch.status, rsp_ch.occupancy);
            results_seen++;
         end
      end
   end

   // Watchdog: counts cycles in which neither channel completes a handshake.
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_MAX);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
